// ===== hdl/esfd_pkg.sv =====
package esfd_pkg;

	localparam int COUNT_W = 9;
	localparam int MAX_FRAME_DEF = 256;
	localparam logic [7:0] ESC_BYTE = 8'h01;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_LEAD = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		REG_ESCAPE_OFFSET = 2'd0,
		REG_HEADER_BYTES = 2'd1,
		REG_LENGTH_POSITION = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] escape_offset;
		logic [4:0] header_bytes;
		logic [3:0] length_position;
	} cfg_t;

	typedef struct packed {
		phase_t phase;
		logic esc;
		logic [7:0] held;
		logic [COUNT_W-1:0] count;
		logic [7:0] cap;
		logic ovf;
	} state_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic last;
		logic frame_ok;
	} result_t;

	localparam cfg_t CFG_RESET = '{
		escape_offset: 8'd16,
		header_bytes: 5'd4,
		length_position: 4'd3
	};

	localparam state_t STATE_RESET = '{
		phase: PH_HUNT,
		esc: 1'b0,
		held: 8'h00,
		count: '0,
		cap: 8'h00,
		ovf: 1'b0
	};

endpackage

// ===== hdl/esfd_step.sv =====
module esfd_step #(
	parameter int MAX_FRAME = esfd_pkg::MAX_FRAME_DEF
) (
	input  esfd_pkg::state_t  cur,
	input  esfd_pkg::cfg_t    cfg,
	input  logic [7:0]        rx,
	output esfd_pkg::state_t  nxt,
	output logic              res_valid,
	output esfd_pkg::result_t res
);

	localparam logic [esfd_pkg::COUNT_W-1:0] CNT_MAX = esfd_pkg::COUNT_W'(MAX_FRAME);

	function automatic esfd_pkg::state_t count_byte(input esfd_pkg::state_t s,
			input logic [7:0] v, input logic [3:0] lp);
		esfd_pkg::state_t r;
		r = s;
		if (s.count == esfd_pkg::COUNT_W'(lp)) begin
			r.cap = v;
		end
		if (s.count >= CNT_MAX) begin
			r.ovf = 1'b1;
		end else begin
			r.count = s.count + esfd_pkg::COUNT_W'(1);
		end
		return r;
	endfunction

	function automatic esfd_pkg::state_t open_frame(input esfd_pkg::state_t s);
		esfd_pkg::state_t r;
		r = s;
		r.phase = esfd_pkg::PH_LEAD;
		r.held = 8'h00;
		r.count = '0;
		r.cap = 8'h00;
		r.ovf = 1'b0;
		return r;
	endfunction

	esfd_pkg::state_t s;
	logic [7:0] lead;
	logic [7:0] v;
	logic [esfd_pkg::COUNT_W-1:0] want;
	logic body;

	always_comb begin
		s = cur;
		body = 1'b0;
		res_valid = 1'b0;
		res.data_byte = cur.held;
		res.last = 1'b0;
		res.frame_ok = 1'b0;
		lead = cur.esc ? (8'h00 - cfg.escape_offset) : 8'h00;
		want = esfd_pkg::COUNT_W'(cfg.header_bytes) + esfd_pkg::COUNT_W'(cur.cap);

		case (cur.phase)
			esfd_pkg::PH_HUNT: begin
				if (rx == 8'h00) begin
					s = open_frame(cur);
				end
			end
			esfd_pkg::PH_LEAD: begin
				if (rx != 8'h00) begin
					s.esc = 1'b0;
					s.held = lead;
					s = count_byte(s, lead, cfg.length_position);
					s.phase = esfd_pkg::PH_BODY;
					body = 1'b1;
				end
			end
			esfd_pkg::PH_BODY: begin
				if (rx == 8'h00) begin
					res_valid = 1'b1;
					res.last = 1'b1;
					res.frame_ok = !cur.ovf && (cur.count == want);
					s = open_frame(cur);
				end else begin
					body = 1'b1;
				end
			end
			default: begin
				s.phase = esfd_pkg::PH_HUNT;
			end
		endcase

		v = s.esc ? (rx - cfg.escape_offset) : rx;
		if (body) begin
			if (rx == esfd_pkg::ESC_BYTE) begin
				s.esc = 1'b1;
			end else begin
				res_valid = 1'b1;
				res.data_byte = s.held;
				s.esc = 1'b0;
				s.held = v;
				s = count_byte(s, v, cfg.length_position);
			end
		end
		nxt = s;
	end

endmodule

// ===== hdl/escape_stuffing_frame_decoder.sv =====
// A byte accepted into the input register is decoded by the combinational step, and the
// result beat it releases is registered in the result register when the step advances.
// Throughput: one input byte per cycle, set by the single decode step between the
// input register and the result register; output stalls back up through both.
// Reset (arst_n low) returns to hunting for a zero, clears the escape and frame
// state, empties both registers and restores the register defaults 16, 4 and 3.
module escape_stuffing_frame_decoder #(
	parameter int MAX_FRAME = esfd_pkg::MAX_FRAME_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       rx_valid,
	output logic       rx_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] data_byte,
	output logic       last,
	output logic       frame_ok
);

	esfd_pkg::cfg_t cfg_q;
	esfd_pkg::state_t state_q;
	esfd_pkg::state_t state_nxt;
	esfd_pkg::result_t res;
	esfd_pkg::result_t res_q;
	logic res_valid;
	logic valid_s1;
	logic [7:0] byte_s1;
	logic out_valid_q;
	logic advance;

	assign cfg_ready = 1'b1;
	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign rx_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= esfd_pkg::CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				esfd_pkg::REG_ESCAPE_OFFSET: cfg_q.escape_offset <= cfg_data;
				esfd_pkg::REG_HEADER_BYTES: cfg_q.header_bytes <= cfg_data[4:0];
				esfd_pkg::REG_LENGTH_POSITION: cfg_q.length_position <= cfg_data[3:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	esfd_step #(
		.MAX_FRAME(MAX_FRAME)
	) u_step (
		.cur(state_q),
		.cfg(cfg_q),
		.rx(byte_s1),
		.nxt(state_nxt),
		.res_valid(res_valid),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= esfd_pkg::STATE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance && res_valid) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign data_byte = res_q.data_byte;
	assign last = res_q.last;
	assign frame_ok = res_q.frame_ok;

	// A byte waiting in the input register is never overwritten before it is decoded.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("input register overwritten while stalled");

	// No result beat comes out of the decode step while hunting for a delimiter.
	a_hunt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> state_q.phase != esfd_pkg::PH_HUNT)
		else $error("result produced while hunting");

	// The decoded byte count saturates at the frame limit.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.count <= esfd_pkg::COUNT_W'(MAX_FRAME))
		else $error("decoded count beyond frame limit");

	// A frame good flag is only ever reported on the final beat of a frame.
	a_ok_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.frame_ok |-> res_q.last)
		else $error("frame good flag without last");

endmodule
